// ===== rtl/core/gpsr_pkg.sv =====
// Shared types and constants of the game pad serial responder.
`default_nettype none

package gpsr_pkg;

	localparam int NUM_PORTS_DEF = 2;

	typedef enum logic [1:0] {
		ACT_EXCH  = 2'd0,
		ACT_BEGIN = 2'd1,
		ACT_END   = 2'd2
	} gpsr_action_t;

	localparam logic [7:0] CMD_ADDR   = 8'h01;
	localparam logic [7:0] CMD_POLL   = 8'h42;
	localparam logic [7:0] CMD_CONFIG = 8'h43;
	localparam logic [7:0] CMD_SETMD  = 8'h44;
	localparam logic [7:0] CMD_STATUS = 8'h45;
	localparam logic [7:0] CMD_CONST1 = 8'h46;
	localparam logic [7:0] CMD_CONST2 = 8'h47;
	localparam logic [7:0] CMD_CONST3 = 8'h4C;
	localparam logic [7:0] CMD_MOTOR  = 8'h4D;

	localparam logic [7:0] ID_DIGITAL = 8'h41;
	localparam logic [7:0] ID_ANALOG  = 8'h73;
	localparam logic [7:0] ID_CONFIG  = 8'hF3;
	localparam logic [7:0] ID_READY   = 8'h5A;
	localparam logic [7:0] IDLE_BYTE  = 8'hFF;
	localparam logic [7:0] LOCK_KEY   = 8'h03;

	localparam int MB_CONFIG = 0;
	localparam int MB_ANALOG = 1;
	localparam int MB_LOCKED = 2;
	localparam int MB_QUERY  = 3;

	localparam logic [3:0] CNT_MAX = 4'd9;

	typedef struct packed {
		logic [1:0]  action;
		logic        port;
		logic [7:0]  tx_byte;
		logic [15:0] buttons_pressed;
		logic [7:0]  left_x;
		logic [7:0]  left_y;
		logic [7:0]  right_x;
		logic [7:0]  right_y;
	} gpsr_item_t;

	function automatic logic is_config_cmd(input logic [7:0] c);
		return c == CMD_SETMD || c == CMD_STATUS || c == CMD_CONST1 ||
			c == CMD_CONST2 || c == CMD_CONST3 || c == CMD_MOTOR;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gpsr_if.sv =====
// Valid/ready channel interfaces for request and reply words.
`default_nettype none

interface gpsr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic        port;
	logic [7:0]  tx_byte;
	logic [15:0] buttons_pressed;
	logic [7:0]  left_x;
	logic [7:0]  left_y;
	logic [7:0]  right_x;
	logic [7:0]  right_y;

	modport source (
		output valid, action, port, tx_byte, buttons_pressed,
		output left_x, left_y, right_x, right_y,
		input  ready
	);
	modport sink (
		input  valid, action, port, tx_byte, buttons_pressed,
		input  left_x, left_y, right_x, right_y,
		output ready
	);
endinterface

interface gpsr_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       ack;

	modport source (output valid, rx_byte, ack, input ready);
	modport sink (input valid, rx_byte, ack, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gpsr_reply.sv =====
// Reply byte decode and mode bit update for one exchanged byte.
`default_nettype none

module gpsr_reply (
	input  wire gpsr_pkg::gpsr_item_t item,
	input  wire logic [3:0]           idx,
	input  wire logic [7:0]           cmd,
	input  wire logic [3:0]           mb,
	output logic [7:0]                rx,
	output logic [3:0]                mb_next
);

	logic [15:0] btn;
	logic        analog;
	logic        cfg;
	logic        q;
	logic        poll_an;
	logic [7:0]  v;

	always_comb begin
		btn     = ~item.buttons_pressed;
		v       = item.tx_byte;
		analog  = mb[gpsr_pkg::MB_ANALOG];
		cfg     = mb[gpsr_pkg::MB_CONFIG];
		q       = mb[gpsr_pkg::MB_QUERY];
		poll_an = (cmd == gpsr_pkg::CMD_POLL) && analog;
		mb_next = mb;
		rx      = gpsr_pkg::IDLE_BYTE;
		case (idx)
			4'd0: rx = gpsr_pkg::IDLE_BYTE;
			4'd1: rx = cfg ? gpsr_pkg::ID_CONFIG :
				(analog ? gpsr_pkg::ID_ANALOG : gpsr_pkg::ID_DIGITAL);
			4'd2: rx = gpsr_pkg::ID_READY;
			4'd3: begin
				if (cmd == gpsr_pkg::CMD_STATUS) begin
					rx = 8'h01;
				end else if (cmd == gpsr_pkg::CMD_CONST1 || cmd == gpsr_pkg::CMD_CONST3) begin
					mb_next[gpsr_pkg::MB_QUERY] = v[0];
					rx = 8'h00;
				end else if (cmd == gpsr_pkg::CMD_CONST2 || cmd == gpsr_pkg::CMD_MOTOR) begin
					rx = 8'h00;
				end else begin
					if (cmd == gpsr_pkg::CMD_CONFIG) begin
						mb_next[gpsr_pkg::MB_CONFIG] = (v == gpsr_pkg::CMD_ADDR);
					end else if (cmd == gpsr_pkg::CMD_SETMD && cfg &&
							!mb[gpsr_pkg::MB_LOCKED]) begin
						mb_next[gpsr_pkg::MB_ANALOG] = (v == gpsr_pkg::CMD_ADDR);
					end
					rx = (cmd == gpsr_pkg::CMD_POLL) ? btn[7:0] : 8'h00;
				end
			end
			4'd4: begin
				if (cmd == gpsr_pkg::CMD_STATUS) begin
					rx = 8'h02;
				end else if (cmd == gpsr_pkg::CMD_CONST1 || cmd == gpsr_pkg::CMD_CONST2 ||
						cmd == gpsr_pkg::CMD_CONST3) begin
					rx = 8'h00;
				end else if (cmd == gpsr_pkg::CMD_MOTOR) begin
					rx = 8'h01;
				end else begin
					if (cmd == gpsr_pkg::CMD_SETMD && cfg) begin
						mb_next[gpsr_pkg::MB_LOCKED] = (v == gpsr_pkg::LOCK_KEY);
					end
					rx = (cmd == gpsr_pkg::CMD_POLL) ? btn[15:8] : 8'h00;
				end
			end
			4'd5: begin
				if (cmd == gpsr_pkg::CMD_STATUS) rx = analog ? 8'h01 : 8'h00;
				else if (cmd == gpsr_pkg::CMD_CONST1) rx = 8'h01;
				else if (cmd == gpsr_pkg::CMD_CONST2) rx = 8'h02;
				else if (cmd == gpsr_pkg::CMD_CONST3) rx = 8'h00;
				else if (cmd == gpsr_pkg::CMD_MOTOR) rx = 8'hFF;
				else rx = poll_an ? item.right_x : 8'h00;
			end
			4'd6: begin
				if (cmd == gpsr_pkg::CMD_STATUS) rx = 8'h02;
				else if (cmd == gpsr_pkg::CMD_CONST1) rx = q ? 8'h01 : 8'h02;
				else if (cmd == gpsr_pkg::CMD_CONST2) rx = 8'h00;
				else if (cmd == gpsr_pkg::CMD_CONST3) rx = q ? 8'h07 : 8'h04;
				else if (cmd == gpsr_pkg::CMD_MOTOR) rx = 8'hFF;
				else rx = poll_an ? item.right_y : 8'h00;
			end
			4'd7: begin
				if (cmd == gpsr_pkg::CMD_STATUS) rx = 8'h01;
				else if (cmd == gpsr_pkg::CMD_CONST1) rx = q ? 8'h01 : 8'h00;
				else if (cmd == gpsr_pkg::CMD_CONST2) rx = 8'h01;
				else if (cmd == gpsr_pkg::CMD_CONST3) rx = 8'h00;
				else if (cmd == gpsr_pkg::CMD_MOTOR) rx = 8'hFF;
				else rx = poll_an ? item.left_x : 8'h00;
			end
			4'd8: begin
				if (cmd == gpsr_pkg::CMD_STATUS) rx = 8'h00;
				else if (cmd == gpsr_pkg::CMD_CONST1) rx = q ? 8'h14 : 8'h0A;
				else if (cmd == gpsr_pkg::CMD_CONST2 || cmd == gpsr_pkg::CMD_CONST3) rx = 8'h00;
				else if (cmd == gpsr_pkg::CMD_MOTOR) rx = 8'hFF;
				else rx = poll_an ? item.left_y : 8'h00;
			end
			default: rx = gpsr_pkg::IDLE_BYTE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/game_pad_serial_responder_unit.sv =====
// Top level of the game pad serial responder: input register, decode, reply register.
// Throughput: one request word per cycle, but an exchange word waits in the input
// register while a full reply is not taken; begin and end words give no reply.
// The reply register lets a new word in while the last reply waits to be taken.
// Reset (arst_n low, asynchronous) deselects, clears the byte counter, addressing,
// command and all per-port mode bits, and empties both registers.
`default_nettype none

module game_pad_serial_responder_unit #(
	parameter int NUM_PORTS = gpsr_pkg::NUM_PORTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	gpsr_req_if.sink  req,
	gpsr_rsp_if.source rsp
);

	gpsr_pkg::gpsr_item_t req_item;
	gpsr_pkg::gpsr_item_t item_s1;
	logic                 v_s1;

	logic       sel_q, active_q, addr_q;
	logic [3:0] cnt_q;
	logic [7:0] cmd_q;
	logic [3:0] mode_q [NUM_PORTS];

	logic       sel_n, active_n, addr_n;
	logic [3:0] cnt_n;
	logic [7:0] cmd_n;

	logic       rsp_v_q, ack_q;
	logic [7:0] rx_q;

	logic       out_free, is_exch, adv, present, respond, mode_we, cfg_now, ack_n;
	logic [3:0] mb_cur, mb_next;
	logic [7:0] rx_dec, rx_n;
	logic [NUM_PORTS-1:0] port_hit;

	assign req_item = '{
		action:          req.action,
		port:            req.port,
		tx_byte:         req.tx_byte,
		buttons_pressed: req.buttons_pressed,
		left_x:          req.left_x,
		left_y:          req.left_y,
		right_x:         req.right_x,
		right_y:         req.right_y
	};

	assign out_free  = !rsp_v_q || rsp.ready;
	assign is_exch   = item_s1.action == gpsr_pkg::ACT_EXCH;
	assign adv       = v_s1 && (!is_exch || out_free);
	assign req.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req_item;
		end
	end

	assign present = int'(active_q) < NUM_PORTS;

	always_comb begin
		mb_cur = '0;
		for (int p = 0; p < NUM_PORTS; p++) begin
			port_hit[p] = int'(active_q) == p;
			if (port_hit[p]) mb_cur = mb_cur | mode_q[p];
		end
	end

	gpsr_reply u_reply (
		.item    (item_s1),
		.idx     (cnt_q),
		.cmd     (cmd_n),
		.mb      (mb_cur),
		.rx      (rx_dec),
		.mb_next (mb_next)
	);

	always_comb begin
		sel_n    = sel_q;
		active_n = active_q;
		addr_n   = addr_q;
		cnt_n    = cnt_q;
		cmd_n    = cmd_q;
		cfg_now  = present && mb_cur[gpsr_pkg::MB_CONFIG];
		respond  = 1'b0;
		case (gpsr_pkg::gpsr_action_t'(item_s1.action))
			gpsr_pkg::ACT_EXCH: begin
				if (cnt_q == 4'd0) begin
					addr_n = (item_s1.tx_byte == gpsr_pkg::CMD_ADDR) && present;
				end else if (cnt_q == 4'd1 && addr_q) begin
					cmd_n  = item_s1.tx_byte;
					addr_n = item_s1.tx_byte == gpsr_pkg::CMD_POLL ||
						item_s1.tx_byte == gpsr_pkg::CMD_CONFIG ||
						(cfg_now && gpsr_pkg::is_config_cmd(item_s1.tx_byte));
				end
				respond = sel_q && addr_n && present;
				if (cnt_q < gpsr_pkg::CNT_MAX) cnt_n = cnt_q + 4'd1;
			end
			gpsr_pkg::ACT_BEGIN: begin
				if (!sel_q) begin
					cnt_n  = '0;
					addr_n = 1'b0;
					cmd_n  = '0;
				end
				sel_n    = 1'b1;
				active_n = item_s1.port;
			end
			gpsr_pkg::ACT_END: begin
				if (sel_q) begin
					sel_n    = 1'b0;
					active_n = 1'b0;
					cnt_n    = '0;
					addr_n   = 1'b0;
					cmd_n    = '0;
				end
			end
			default: begin
			end
		endcase
		rx_n  = respond ? rx_dec : gpsr_pkg::IDLE_BYTE;
		if (cmd_n == gpsr_pkg::CMD_POLL && !mb_next[gpsr_pkg::MB_ANALOG]) begin
			ack_n = respond && (cnt_q < 4'd4);
		end else begin
			ack_n = respond && (cnt_q < 4'd8);
		end
		mode_we = adv && respond;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q    <= 1'b0;
			active_q <= 1'b0;
			addr_q   <= 1'b0;
			cnt_q    <= '0;
			cmd_q    <= '0;
		end else if (adv) begin
			sel_q    <= sel_n;
			active_q <= active_n;
			addr_q   <= addr_n;
			cnt_q    <= cnt_n;
			cmd_q    <= cmd_n;
		end
	end

	for (genvar p = 0; p < NUM_PORTS; p++) begin : g_mode
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mode_q[p] <= '0;
			end else if (mode_we && port_hit[p]) begin
				mode_q[p] <= mb_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (adv && is_exch) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_exch) begin
			rx_q  <= rx_n;
			ack_q <= ack_n;
		end
	end

	assign rsp.valid   = rsp_v_q;
	assign rsp.rx_byte = rx_q;
	assign rsp.ack     = ack_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gpsr_pkg::CNT_MAX)
		else $error("byte counter past saturation");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && sel_q && item_s1.action == gpsr_pkg::ACT_END) |=>
		(!sel_q && cnt_q == 4'd0 && !addr_q && !active_q))
		else $error("end word left transaction state");

	a_exch_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_exch) |=> rsp_v_q)
		else $error("exchange word gave no reply");

	a_ack_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_exch && ack_n) |-> (sel_q && present))
		else $error("ack without selected present pad");

endmodule

`default_nettype wire
